// ===== src/cscf_pkg.sv =====
`default_nettype none

package cscf_pkg;

  // Fixed widths of the stream fields.
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 32;

  // Depth of the queue between the classifier and the output stage.
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // Character codes.
  localparam logic [ByteW-1:0] NewlineByte = 8'h0A;
  localparam logic [ByteW-1:0] NulByte     = 8'h00;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    RegLineByte  = 2'd0,
    RegBlockByte = 2'd1,
    RegDouble    = 2'd2,
    RegRetain    = 2'd3
  } reg_index_e;

  // Scanner phase, one-hot.
  typedef enum logic [5:0] {
    PhNormal  = 6'b000001,
    PhPending = 6'b000010,
    PhLine    = 6'b000100,
    PhBlock   = 6'b001000,
    PhStar    = 6'b010000,
    PhAfter   = 6'b100000
  } phase_e;

  // Live configuration seen by the classifier.
  typedef struct packed {
    logic [ByteW-1:0] line_byte;
    logic [ByteW-1:0] block_byte;
    logic             double_mode;
    logic             retain;
  } cfg_t;

  // One queued word: one or two results caused by a single input word.
  typedef struct packed {
    logic              dual;
    logic [ByteW-1:0]  byte0;
    logic [CountW-1:0] count0;
    logic [ByteW-1:0]  byte1;
    logic [CountW-1:0] count1;
  } entry_t;

endpackage

`default_nettype wire

// ===== src/cscf_front.sv =====
`default_nettype none

module cscf_front #(
  parameter int unsigned LINE_BITS = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire cscf_pkg::cfg_t                cfg_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [cscf_pkg::ByteW-1:0]    text_byte_i,
  input  wire logic                          end_of_text_i,
  output logic                               push_o,
  output cscf_pkg::entry_t                   entry_o,
  input  wire logic                          queue_ready_i
);

  localparam logic [LINE_BITS-1:0] LineMax = '1;
  localparam logic [LINE_BITS-1:0] LineOne = LINE_BITS'(1);

  cscf_pkg::phase_e          phase_q, phase_d;
  logic [LINE_BITS-1:0]      line_q, line_d, line_new;
  logic                      fire, emit;
  logic                      is_nl, is_lc, is_mc;
  logic [cscf_pkg::CountW-1:0] cnt_before, cnt_after;

  assign in_ready_o = queue_ready_i;
  assign fire       = in_valid_i && queue_ready_i;
  assign push_o     = fire && emit;

  assign is_nl = (text_byte_i == cscf_pkg::NewlineByte);
  assign is_lc = (text_byte_i == cfg_i.line_byte);
  assign is_mc = (text_byte_i == cfg_i.block_byte);

  // Newlines count everywhere, comments included; the counter saturates.
  assign line_new   = (is_nl && (line_q != LineMax)) ? line_q + LineOne : line_q;
  assign cnt_before = cscf_pkg::CountW'(line_q);
  assign cnt_after  = cscf_pkg::CountW'(line_new);

  // Phase update and result selection for the current word.
  always_comb begin
    phase_d       = cscf_pkg::PhNormal;
    emit          = 1'b0;
    entry_o.dual  = 1'b0;
    entry_o.byte0 = text_byte_i;
    entry_o.count0 = cnt_after;
    entry_o.byte1 = text_byte_i;
    entry_o.count1 = cnt_after;
    case (phase_q)
      cscf_pkg::PhPending: begin
        if (is_mc) begin
          phase_d       = cscf_pkg::PhBlock;
          emit          = end_of_text_i;
          entry_o.byte0 = cscf_pkg::NulByte;
        end else if (is_lc) begin
          if (is_nl) begin
            phase_d = cscf_pkg::PhNormal;
            emit    = 1'b1;
          end else begin
            phase_d       = cscf_pkg::PhLine;
            emit          = end_of_text_i;
            entry_o.byte0 = cscf_pkg::NulByte;
          end
        end else begin
          // The held comment byte goes out first, with the count before this word.
          phase_d        = cscf_pkg::PhNormal;
          emit           = 1'b1;
          entry_o.dual   = 1'b1;
          entry_o.byte0  = cfg_i.line_byte;
          entry_o.count0 = cnt_before;
        end
      end
      cscf_pkg::PhLine: begin
        if (is_nl) begin
          phase_d = cscf_pkg::PhNormal;
          emit    = 1'b1;
        end else begin
          phase_d       = cscf_pkg::PhLine;
          emit          = end_of_text_i;
          entry_o.byte0 = cscf_pkg::NulByte;
        end
      end
      cscf_pkg::PhBlock, cscf_pkg::PhStar: begin
        if ((phase_q == cscf_pkg::PhStar) && is_lc) begin
          phase_d = cscf_pkg::PhAfter;
        end else if (is_mc) begin
          phase_d = cscf_pkg::PhStar;
        end else begin
          phase_d = cscf_pkg::PhBlock;
        end
        emit          = end_of_text_i;
        entry_o.byte0 = cscf_pkg::NulByte;
      end
      cscf_pkg::PhAfter: begin
        phase_d = cscf_pkg::PhNormal;
        emit    = 1'b1;
      end
      default: begin
        if (cfg_i.retain || !is_lc) begin
          phase_d = cscf_pkg::PhNormal;
          emit    = 1'b1;
        end else if (!cfg_i.double_mode) begin
          phase_d       = cscf_pkg::PhLine;
          emit          = end_of_text_i;
          entry_o.byte0 = cscf_pkg::NulByte;
        end else if (end_of_text_i) begin
          phase_d = cscf_pkg::PhNormal;
          emit    = 1'b1;
        end else begin
          phase_d = cscf_pkg::PhPending;
        end
      end
    endcase
  end

  // The end of the text returns phase and counter to their reset values.
  always_comb begin
    line_d = line_new;
    if (end_of_text_i) begin
      line_d = LineOne;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= cscf_pkg::PhNormal;
      line_q  <= LineOne;
    end else if (fire) begin
      phase_q <= end_of_text_i ? cscf_pkg::PhNormal : phase_d;
      line_q  <= line_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/cscf_queue.sv =====
`default_nettype none

module cscf_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire cscf_pkg::entry_t push_data_i,
  output logic                  push_ready_o,
  output logic                  pop_valid_o,
  output cscf_pkg::entry_t      pop_data_o,
  input  wire logic             pop_i
);

  cscf_pkg::entry_t                 mem_q [cscf_pkg::QueueDepth];
  logic [cscf_pkg::QueuePtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [cscf_pkg::QueueCntW-1:0]   count_q, count_d;
  logic                             do_push, do_pop;

  localparam logic [cscf_pkg::QueueCntW-1:0] Full =
    cscf_pkg::QueueCntW'(cscf_pkg::QueueDepth);
  localparam logic [cscf_pkg::QueuePtrW-1:0] Last =
    cscf_pkg::QueuePtrW'(cscf_pkg::QueueDepth - 1);

  assign push_ready_o = (count_q != Full);
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  // Occupancy follows pushes and pops.
  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + cscf_pkg::QueueCntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - cscf_pkg::QueueCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == Last) ? '0 : wr_ptr_q + cscf_pkg::QueuePtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == Last) ? '0 : rd_ptr_q + cscf_pkg::QueuePtrW'(1);
      end
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== src/cscf_back.sv =====
`default_nettype none

module cscf_back (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         q_valid_i,
  input  wire cscf_pkg::entry_t             q_data_i,
  output logic                              q_pop_o,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [cscf_pkg::ByteW-1:0]        out_byte_o,
  output logic [cscf_pkg::CountW-1:0]       line_count_o,
  output logic                              run_last_o
);

  cscf_pkg::entry_t entry_q;
  logic             valid_q, sel_q;
  logic             take, final_res;

  assign take      = valid_q && out_ready_i;
  assign final_res = !entry_q.dual || sel_q;
  assign q_pop_o   = q_valid_i && (!valid_q || (take && final_res));

  assign out_valid_o  = valid_q;
  assign out_byte_o   = sel_q ? entry_q.byte1 : entry_q.byte0;
  assign line_count_o = sel_q ? entry_q.count1 : entry_q.count0;
  assign run_last_o   = final_res;

  // Walk through the one or two results of the held word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_q   <= 1'b0;
    end else if (q_pop_o) begin
      valid_q <= 1'b1;
      sel_q   <= 1'b0;
    end else if (take) begin
      if (final_res) begin
        valid_q <= 1'b0;
        sel_q   <= 1'b0;
      end else begin
        sel_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      entry_q <= q_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== src/comment_stripping_char_filter.sv =====
`default_nettype none

// Channel  Direction  Payload
// s_axis   in         tdata: text_byte; tlast: end_of_text
// m_axis   out        tdata: out_byte, line_count; tlast: run_last
// cfg      in         index 0..3, data: register value (low bits used)
//
// One input word is taken per cycle while s_axis_tready is high; it yields zero,
// one or two output words. The first of them passes through the queue and the
// output register of the output stage before it is offered on m_axis.
// The classifier updates the scan phase and line counter for each accepted word,
// and the output stage sends one word per cycle while m_axis_tready is high, so
// a word yielding two results holds the output stage until both are taken.
// A two-entry queue decouples the two sides; back-pressure on m_axis, or a run
// of words yielding two results, fills it and then drops s_axis_tready.
// Reset brings normal phase, line one and register defaults.

module comment_stripping_char_filter #(
  parameter int unsigned LINE_BITS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // [7:0] out_byte, [39:8] line_count
  output logic             m_axis_tlast,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [7:0]  cfg_data_i
);

  cscf_pkg::cfg_t   cfg_q;
  cscf_pkg::entry_t push_entry, pop_entry;
  logic             push, q_ready, q_valid, q_pop;
  logic [cscf_pkg::ByteW-1:0]  out_byte;
  logic [cscf_pkg::CountW-1:0] line_count;

  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.line_byte   <= 8'd47;
      cfg_q.block_byte  <= 8'd42;
      cfg_q.double_mode <= 1'b1;
      cfg_q.retain      <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cscf_pkg::reg_index_e'(cfg_index_i))
        cscf_pkg::RegLineByte:  cfg_q.line_byte   <= cfg_data_i;
        cscf_pkg::RegBlockByte: cfg_q.block_byte  <= cfg_data_i;
        cscf_pkg::RegDouble:    cfg_q.double_mode <= cfg_data_i[0];
        cscf_pkg::RegRetain:    cfg_q.retain      <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  cscf_front #(
    .LINE_BITS(LINE_BITS)
  ) u_front (
    .clk_i,
    .rst_ni,
    .cfg_i         (cfg_q),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .text_byte_i   (s_axis_tdata),
    .end_of_text_i (s_axis_tlast),
    .push_o        (push),
    .entry_o       (push_entry),
    .queue_ready_i (q_ready)
  );

  cscf_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i       (push),
    .push_data_i  (push_entry),
    .push_ready_o (q_ready),
    .pop_valid_o  (q_valid),
    .pop_data_o   (pop_entry),
    .pop_i        (q_pop)
  );

  cscf_back u_back (
    .clk_i,
    .rst_ni,
    .q_valid_i    (q_valid),
    .q_data_i     (pop_entry),
    .q_pop_o      (q_pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_byte_o   (out_byte),
    .line_count_o (line_count),
    .run_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {line_count, out_byte};

endmodule

`default_nettype wire
